// File: rtl/spsr_pkg.sv
// Shared types and constants for the sorted posting search/remove block.
// Field widths, op and status codes, register indexes, control/status structs.
// No dependencies.
package spsr_pkg;

   localparam int STORE_DEPTH_DEFAULT = 1024;

   localparam int OP_W       = 2;
   localparam int KEY_W      = 32;
   localparam int ENTRY_W    = 3 * KEY_W;
   localparam int STATUS_W   = 3;
   localparam int HIT_W      = 10;
   localparam int LEFT_W     = 11;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 1;

   typedef logic [OP_W-1:0]     op_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam op_type OP_LOAD  = 2'd0;
   localparam op_type OP_FIND  = 2'd1;
   localparam op_type OP_CLEAR = 2'd2;

   localparam status_type ST_LOADED  = 3'd0;
   localparam status_type ST_REMOVED = 3'd1;
   localparam status_type ST_MISSING = 3'd2;
   localparam status_type ST_FULL    = 3'd3;
   localparam status_type ST_CLEARED = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_USE_SECTION  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_USE_POSITION = 1'b1;

   // controller -> datapath
   typedef struct packed {
      logic capture;
      logic load;
      logic clear;
      logic set_missing;
      logic search_init;
      logic probe;
      logic compare;
      logic shift_step;
      logic remove_done;
      logic publish;
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      op_type op;
      logic   search_open;
      logic   hit;
      logic   shift_done;
   } dp_stat_type;

endpackage

// File: rtl/spsr_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module spsr_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/spsr_ctrl.sv
// Sequencer for the posting store: accept, execute, binary-search probes,
// shift-down removal and result hand-off. Depends on spsr_pkg.
module spsr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  spsr_pkg::dp_stat_type dp_stat,
   output spsr_pkg::dp_cmd_type  dp_cmd
);

   import spsr_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE    = 6'b000001,
      S_EXEC    = 6'b000010,
      S_PROBE   = 6'b000100,
      S_COMPARE = 6'b001000,
      S_SHIFT   = 6'b010000,
      S_DONE    = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      dp_cmd       = '0;
      req_stall    = 1'b1;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               dp_cmd.capture = 1'b1;
               state_in       = S_EXEC;
            end
         end
         S_EXEC: begin
            case (dp_stat.op)
               OP_LOAD: begin
                  dp_cmd.load = 1'b1;
                  state_in    = S_DONE;
               end
               OP_FIND: begin
                  dp_cmd.search_init = 1'b1;
                  state_in           = S_PROBE;
               end
               OP_CLEAR: begin
                  dp_cmd.clear = 1'b1;
                  state_in     = S_DONE;
               end
               default: begin
                  dp_cmd.set_missing = 1'b1;
                  state_in           = S_DONE;
               end
            endcase
         end
         S_PROBE: begin
            if (dp_stat.search_open) begin
               dp_cmd.probe = 1'b1;
               state_in     = S_COMPARE;
            end else begin
               dp_cmd.set_missing = 1'b1;
               state_in           = S_DONE;
            end
         end
         S_COMPARE: begin
            dp_cmd.compare = 1'b1;
            state_in       = dp_stat.hit ? S_SHIFT : S_PROBE;
         end
         S_SHIFT: begin
            if (dp_stat.shift_done) begin
               dp_cmd.remove_done = 1'b1;
               state_in           = S_DONE;
            end else begin
               dp_cmd.shift_step = 1'b1;
            end
         end
         S_DONE: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || !rsp_stall) begin
               dp_cmd.publish = 1'b1;
               rsp_valid_in   = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// File: rtl/spsr_dpath.sv
// Datapath: posting RAM, entry count, search bounds, key compare, shift
// pointers, config flags and the result register. Depends on spsr_pkg, spsr_ram.
module spsr_dpath #(
   parameter int STORE_DEPTH = spsr_pkg::STORE_DEPTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_en,
   input  logic [spsr_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [spsr_pkg::CSR_DATA_W-1:0]      csr_data,
   input  logic [spsr_pkg::OP_W-1:0]            req_op,
   input  logic [spsr_pkg::KEY_W-1:0]           req_doc_id,
   input  logic [spsr_pkg::KEY_W-1:0]           req_sect_num,
   input  logic [spsr_pkg::KEY_W-1:0]           req_token_pos,
   output logic [spsr_pkg::STATUS_W-1:0]        rsp_status,
   output logic [spsr_pkg::HIT_W-1:0]           rsp_hit_index,
   output logic [spsr_pkg::LEFT_W-1:0]          rsp_entries_left,
   input  spsr_pkg::dp_cmd_type                 dp_cmd,
   output spsr_pkg::dp_stat_type                dp_stat
);

   import spsr_pkg::*;

   localparam int AW = $clog2(STORE_DEPTH);
   localparam int CW = $clog2(STORE_DEPTH + 1);

   logic             use_section_ff, use_position_ff;
   op_type           op_ff;
   logic [KEY_W-1:0] rid_ff, sid_ff, pos_ff;
   logic [CW-1:0]    count_ff, count_in;
   logic [CW-1:0]    lo_ff, lo_in, hend_ff, hend_in;
   logic [CW-1:0]    mid_ff, mid_in;
   logic [CW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic             pend_ff, pend_in;
   logic [AW-1:0]    hit_ff, hit_in;
   status_type       status_ff, status_in;
   status_type       rsp_status_ff;
   logic [HIT_W-1:0] rsp_hit_ff;
   logic [LEFT_W-1:0] rsp_left_ff;

   logic [CW-1:0]    span, mid;
   logic             full, issue;
   logic             ram_wr_en, ram_rd_en;
   logic [AW-1:0]    ram_wr_addr, ram_rd_addr;
   logic [ENTRY_W-1:0] ram_wr_data, ram_rd_data;
   logic [KEY_W-1:0] e_rid, e_sid, e_pos;
   logic             rid_eq, sid_eq, pos_eq, rid_lt, sid_lt, pos_lt;
   logic             cmp_eq, cmp_lt;
   logic [AW+HIT_W-1:0]  hit_wide;
   logic [CW+LEFT_W-1:0] left_wide;

   spsr_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // lo/hend is a half-open window; midpoint matches the inclusive search
   assign span  = hend_ff - lo_ff - CW'(1);
   assign mid   = lo_ff + (span >> 1);
   assign full  = (count_ff == CW'(STORE_DEPTH));
   assign issue = (rd_ptr_ff < count_ff);

   assign e_rid  = ram_rd_data[ENTRY_W-1 -: KEY_W];
   assign e_sid  = ram_rd_data[2*KEY_W-1 -: KEY_W];
   assign e_pos  = ram_rd_data[KEY_W-1:0];
   assign rid_eq = (e_rid == rid_ff);
   assign sid_eq = (e_sid == sid_ff);
   assign pos_eq = (e_pos == pos_ff);
   assign rid_lt = (e_rid < rid_ff);
   assign sid_lt = (e_sid < sid_ff);
   assign pos_lt = (e_pos < pos_ff);
   assign cmp_eq = rid_eq && (!use_section_ff || sid_eq) && (!use_position_ff || pos_eq);
   assign cmp_lt = rid_lt
                || (rid_eq && use_section_ff && sid_lt)
                || (rid_eq && (!use_section_ff || sid_eq) && use_position_ff && pos_lt);

   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = count_ff[AW-1:0];
      ram_wr_data = {rid_ff, sid_ff, pos_ff};
      if (dp_cmd.load && !full) begin
         ram_wr_en = 1'b1;
      end else if (dp_cmd.shift_step && pend_ff) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = wr_ptr_ff;
         ram_wr_data = ram_rd_data;
      end
      ram_rd_en   = dp_cmd.probe || (dp_cmd.shift_step && issue);
      ram_rd_addr = dp_cmd.probe ? mid[AW-1:0] : rd_ptr_ff[AW-1:0];
   end

   always_comb begin
      count_in  = count_ff;
      lo_in     = lo_ff;
      hend_in   = hend_ff;
      mid_in    = mid_ff;
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      pend_in   = pend_ff;
      hit_in    = hit_ff;
      status_in = status_ff;
      if (dp_cmd.capture) begin
         hit_in = '0;
      end
      if (dp_cmd.load) begin
         if (full) begin
            status_in = ST_FULL;
         end else begin
            count_in  = count_ff + CW'(1);
            status_in = ST_LOADED;
         end
      end
      if (dp_cmd.clear) begin
         count_in  = '0;
         status_in = ST_CLEARED;
      end
      if (dp_cmd.set_missing) begin
         status_in = ST_MISSING;
      end
      if (dp_cmd.search_init) begin
         lo_in   = '0;
         hend_in = count_ff;
      end
      if (dp_cmd.probe) begin
         mid_in = mid;
      end
      if (dp_cmd.compare) begin
         if (cmp_eq) begin
            hit_in    = mid_ff[AW-1:0];
            wr_ptr_in = mid_ff[AW-1:0];
            rd_ptr_in = mid_ff + CW'(1);
            pend_in   = 1'b0;
         end else if (cmp_lt) begin
            lo_in = mid_ff + CW'(1);
         end else begin
            hend_in = mid_ff;
         end
      end
      if (dp_cmd.shift_step) begin
         // read of entry p lands next cycle and is written to p-1
         if (pend_ff) begin
            wr_ptr_in = wr_ptr_ff + AW'(1);
         end
         if (issue) begin
            rd_ptr_in = rd_ptr_ff + CW'(1);
         end
         pend_in = issue;
      end
      if (dp_cmd.remove_done) begin
         count_in  = count_ff - CW'(1);
         status_in = ST_REMOVED;
      end
   end

   assign hit_wide  = {{HIT_W{1'b0}}, hit_ff};
   assign left_wide = {{LEFT_W{1'b0}}, count_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         use_section_ff  <= 1'b0;
         use_position_ff <= 1'b0;
         count_ff        <= '0;
         pend_ff         <= 1'b0;
      end else begin
         if (csr_write_en && csr_index == CSR_USE_SECTION) begin
            use_section_ff <= csr_data[0];
         end
         if (csr_write_en && csr_index == CSR_USE_POSITION) begin
            use_position_ff <= csr_data[0];
         end
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.capture) begin
         op_ff  <= req_op;
         rid_ff <= req_doc_id;
         sid_ff <= req_sect_num;
         pos_ff <= req_token_pos;
      end
      lo_ff     <= lo_in;
      hend_ff   <= hend_in;
      mid_ff    <= mid_in;
      rd_ptr_ff <= rd_ptr_in;
      wr_ptr_ff <= wr_ptr_in;
      hit_ff    <= hit_in;
      status_ff <= status_in;
      if (dp_cmd.publish) begin
         rsp_status_ff <= status_ff;
         rsp_hit_ff    <= hit_wide[HIT_W-1:0];
         rsp_left_ff   <= left_wide[LEFT_W-1:0];
      end
   end

   assign dp_stat.op          = op_ff;
   assign dp_stat.search_open = (lo_ff < hend_ff);
   assign dp_stat.hit         = cmp_eq;
   assign dp_stat.shift_done  = !pend_ff && !issue;

   assign rsp_status       = rsp_status_ff;
   assign rsp_hit_index    = rsp_hit_ff;
   assign rsp_entries_left = rsp_left_ff;

endmodule

// File: rtl/sorted_posting_search_remove_core.sv
// Steps from accept to rsp_valid: load, clear and an unused op execute, then publish; a find
// probes, one RAM read and one compare each, at most log2(STORE_DEPTH)+1 probes; a find hit
// then shifts the later entries down one place before the result is published.
// One transaction in flight; the next is accepted once the result is registered;
// a stalled result delays the next result's hand-off.
// Reset (sync, active high) empties the store count and clears both flags; RAM is not swept.
module sorted_posting_search_remove_core #(
   parameter int STORE_DEPTH = spsr_pkg::STORE_DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_en,
   input  logic [spsr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [spsr_pkg::CSR_DATA_W-1:0] csr_data,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [spsr_pkg::OP_W-1:0]       req_op,
   input  logic [spsr_pkg::KEY_W-1:0]      req_doc_id,
   input  logic [spsr_pkg::KEY_W-1:0]      req_sect_num,
   input  logic [spsr_pkg::KEY_W-1:0]      req_token_pos,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [spsr_pkg::STATUS_W-1:0]   rsp_status,
   output logic [spsr_pkg::HIT_W-1:0]      rsp_hit_index,
   output logic [spsr_pkg::LEFT_W-1:0]     rsp_entries_left
);

   import spsr_pkg::*;

   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;

   spsr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .dp_stat   (dp_stat),
      .dp_cmd    (dp_cmd)
   );

   spsr_dpath #(
      .STORE_DEPTH (STORE_DEPTH)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_op           (req_op),
      .req_doc_id       (req_doc_id),
      .req_sect_num     (req_sect_num),
      .req_token_pos    (req_token_pos),
      .rsp_status       (rsp_status),
      .rsp_hit_index    (rsp_hit_index),
      .rsp_entries_left (rsp_entries_left),
      .dp_cmd           (dp_cmd),
      .dp_stat          (dp_stat)
   );

`ifndef ASSERT_OFF
   // one transaction at a time
   a_single_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while another is in flight");

   a_hit_only_on_remove: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_REMOVED) |-> (rsp_hit_index == '0))
      else $error("hit index nonzero without a removal");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_FULL) |-> (rsp_entries_left == LEFT_W'(STORE_DEPTH)))
      else $error("store-full reported with store not full");

   a_clear_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_CLEARED) |-> (rsp_entries_left == '0))
      else $error("clear left entries behind");
`endif

endmodule
